FILE: rtl/vtp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_pkg
// Types and constants for the vertex transform and perspective divide block.
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    // quotient bits: dividend is tx shifted up by FRAC_BITS
    localparam int DIV_BITS  = W + FRAC_BITS;
    // stages of the matrix front end before the divider chain
    localparam int PRE_STAGES = 3;

    localparam logic [2:0] REG_X_A = 3'd0;
    localparam logic [2:0] REG_X_B = 3'd1;
    localparam logic [2:0] REG_Y_A = 3'd2;
    localparam logic [2:0] REG_Y_B = 3'd3;
    localparam logic [2:0] REG_Z_A = 3'd4;
    localparam logic [2:0] REG_Z_B = 3'd5;

    // one divider cell's contents, handed down the chain whenever the pipe is enabled
    typedef struct packed {
        logic                      vld;
        logic [DIV_BITS-1:0]       nx;    // dividend magnitude shifting out
        logic [DIV_BITS-1:0]       ny;
        logic [W:0]                rx;    // partial remainders
        logic [W:0]                ry;
        logic [DIV_BITS-1:0]       qx;    // quotient bits shifting in
        logic [DIV_BITS-1:0]       qy;
        logic [W-1:0]              dmag;  // divisor magnitude
        logic                      negx;  // quotient sign
        logic                      negy;
        logic [W-1:0]              depth;
        logic                      zero;
        logic                      sat;
    } div_cell_t;

    function automatic logic [W-1:0] sat32(input logic signed [W+24:0] v,
                                           output logic f);
        logic signed [W+24:0] mx;
        logic signed [W+24:0] mn;
        begin
            mx = (W+25)'(signed'({1'b0, {(W-1){1'b1}}}));
            mn = -mx - 1;
            f  = 1'b0;
            if (v > mx) begin f = 1'b1; sat32 = {1'b0, {(W-1){1'b1}}}; end
            else if (v < mn) begin f = 1'b1; sat32 = {1'b1, {(W-1){1'b0}}}; end
            else sat32 = v[W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/vtp_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_div_cell
// One restoring-division step for x and y, with the item's side fields.
// ----------------------------------------------------------------------------
module vtp_div_cell (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  vtp_pkg::div_cell_t cell_in,
    output vtp_pkg::div_cell_t cell_out
);

    vtp_pkg::div_cell_t cell_next;
    logic                                   vld_reg;
    logic [$bits(vtp_pkg::div_cell_t)-2:0]  payload_reg;
    logic [vtp_pkg::W:0] trx;
    logic [vtp_pkg::W:0] try_;
    logic [vtp_pkg::W:0] dext;

    // shift one dividend bit into each remainder and try the subtract
    always_comb
    begin
        cell_next = cell_in;
        dext = {1'b0, cell_in.dmag};
        trx  = {cell_in.rx[vtp_pkg::W-1:0], cell_in.nx[vtp_pkg::DIV_BITS-1]};
        try_ = {cell_in.ry[vtp_pkg::W-1:0], cell_in.ny[vtp_pkg::DIV_BITS-1]};
        cell_next.nx = {cell_in.nx[vtp_pkg::DIV_BITS-2:0], 1'b0};
        cell_next.ny = {cell_in.ny[vtp_pkg::DIV_BITS-2:0], 1'b0};
        if (trx >= dext)
        begin
            cell_next.rx = trx - dext;
            cell_next.qx = {cell_in.qx[vtp_pkg::DIV_BITS-2:0], 1'b1};
        end
        else
        begin
            cell_next.rx = trx;
            cell_next.qx = {cell_in.qx[vtp_pkg::DIV_BITS-2:0], 1'b0};
        end
        if (try_ >= dext)
        begin
            cell_next.ry = try_ - dext;
            cell_next.qy = {cell_in.qy[vtp_pkg::DIV_BITS-2:0], 1'b1};
        end
        else
        begin
            cell_next.ry = try_;
            cell_next.qy = {cell_in.qy[vtp_pkg::DIV_BITS-2:0], 1'b0};
        end
    end

    // valid bit under reset, payload free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= cell_next.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            payload_reg <= cell_next[$bits(vtp_pkg::div_cell_t)-2:0];
    end

    assign cell_out = {vld_reg, payload_reg};

endmodule
`default_nettype wire

FILE: rtl/vtp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vtp_front
// Matrix multiply, rounding, depth and divider cell setup over three stages.
// ----------------------------------------------------------------------------
module vtp_front (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                in_vld,
    input  wire  [31:0]        pos_x,
    input  wire  [31:0]        pos_y,
    input  wire  [31:0]        pos_z,
    input  wire  [63:0]        coef [6],
    output vtp_pkg::div_cell_t cell_out
);

    localparam int PW = 2 * vtp_pkg::W;
    localparam int SW = PW + 3;

    // stage 1: nine products plus offsets
    logic              s1_vld_reg;
    logic signed [PW-1:0] prod_reg [9];
    logic signed [vtp_pkg::W-1:0] off_reg [3];

    // stage 2: rounded rows
    logic              s2_vld_reg;
    logic signed [SW-1:0] row_reg [3];

    logic signed [PW-1:0] prod_next [9];
    logic signed [SW-1:0] row_next [3];
    logic signed [vtp_pkg::W-1:0] pos [3];

    always_comb
    begin
        pos[0] = pos_x;
        pos[1] = pos_y;
        pos[2] = pos_z;
        for (int r = 0; r < 3; r++)
        begin
            prod_next[3*r]   = $signed(coef[2*r][31:0])   * pos[0];
            prod_next[3*r+1] = $signed(coef[2*r][63:32])  * pos[1];
            prod_next[3*r+2] = $signed(coef[2*r+1][31:0]) * pos[2];
        end
    end

    // exact sum then round half up: floor((sum + half) / 2^frac)
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_next[r] = (SW'(prod_reg[3*r]) + SW'(prod_reg[3*r+1])
                          + SW'(prod_reg[3*r+2])
                          + (SW'(off_reg[r]) <<< vtp_pkg::FRAC_BITS)
                          + (SW'(1) <<< (vtp_pkg::FRAC_BITS - 1)))
                          >>> vtp_pkg::FRAC_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
                prod_reg[i] <= prod_next[i];
            for (int r = 0; r < 3; r++)
            begin
                off_reg[r] <= $signed(coef[2*r+1][63:32]);
                row_reg[r] <= row_next[r];
            end
        end
    end

    // stage 3: clamp, depth, signs and magnitudes for the divider chain
    vtp_pkg::div_cell_t c3_next;
    logic                                  c3_vld_reg;
    logic [$bits(vtp_pkg::div_cell_t)-2:0] c3_data_reg;
    logic [vtp_pkg::W-1:0] tx;
    logic [vtp_pkg::W-1:0] ty;
    logic [vtp_pkg::W-1:0] dp;
    logic fx;
    logic fy;
    logic fz;
    logic [vtp_pkg::W-1:0] txm;
    logic [vtp_pkg::W-1:0] tym;

    always_comb
    begin
        tx = vtp_pkg::sat32((vtp_pkg::W+25)'(row_reg[0]), fx);
        ty = vtp_pkg::sat32((vtp_pkg::W+25)'(row_reg[1]), fy);
        dp = vtp_pkg::sat32((vtp_pkg::W+25)'(row_reg[2])
                 - (vtp_pkg::W+25)'(signed'(1 << vtp_pkg::FRAC_BITS)), fz);
        txm = tx[vtp_pkg::W-1] ? (~tx + 1'b1) : tx;
        tym = ty[vtp_pkg::W-1] ? (~ty + 1'b1) : ty;
        c3_next.vld   = s2_vld_reg;
        c3_next.nx    = {txm, {vtp_pkg::FRAC_BITS{1'b0}}};
        c3_next.ny    = {tym, {vtp_pkg::FRAC_BITS{1'b0}}};
        c3_next.rx    = '0;
        c3_next.ry    = '0;
        c3_next.qx    = '0;
        c3_next.qy    = '0;
        c3_next.dmag  = dp[vtp_pkg::W-1] ? (~dp + 1'b1) : dp;
        c3_next.negx  = tx[vtp_pkg::W-1] ^ dp[vtp_pkg::W-1];
        c3_next.negy  = ty[vtp_pkg::W-1] ^ dp[vtp_pkg::W-1];
        c3_next.depth = dp;
        c3_next.zero  = (dp == '0);
        c3_next.sat   = fz | ((dp != '0) & (fx | fy));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c3_vld_reg <= 1'b0;
        else if (en)
            c3_vld_reg <= c3_next.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c3_data_reg <= c3_next[$bits(vtp_pkg::div_cell_t)-2:0];
    end

    assign cell_out = {c3_vld_reg, c3_data_reg};

endmodule
`default_nettype wire

FILE: rtl/vertex_transform_project.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_transform_project
// Affine 3x4 vertex transform followed by a perspective divide.
// ----------------------------------------------------------------------------
// pipeline: front-end stages s1, s2 and c3, then 48 divider cells, then the output register
// throughput: one item per cycle while the output is taken; the whole chain advances together
// the chain stalls only when the output register holds an untaken item
// reset: coefficient registers load the identity matrix, all valid bits clear
// ----------------------------------------------------------------------------
module vertex_transform_project (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [95:0] s_axis_tdata,   // pos_x, pos_y, pos_z
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata,   // proj_x, proj_y, depth
    output logic [1:0]  m_axis_tuser    // zero_divisor, saturated
);

    localparam int NC = vtp_pkg::DIV_BITS;

    logic [63:0] coef_reg [6];
    logic        en;
    logic        out_vld_reg;
    logic [95:0] out_data_reg;
    logic [1:0]  out_user_reg;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= 64'd65536;
            coef_reg[1] <= 64'd0;
            coef_reg[2] <= 64'd281474976710656;
            coef_reg[3] <= 64'd0;
            coef_reg[4] <= 64'd0;
            coef_reg[5] <= 64'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vtp_pkg::REG_X_A: coef_reg[0] <= cfg_data;
                vtp_pkg::REG_X_B: coef_reg[1] <= cfg_data;
                vtp_pkg::REG_Y_A: coef_reg[2] <= cfg_data;
                vtp_pkg::REG_Y_B: coef_reg[3] <= cfg_data;
                vtp_pkg::REG_Z_A: coef_reg[4] <= cfg_data;
                vtp_pkg::REG_Z_B: coef_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe moves unless the output holds an untaken item
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    vtp_pkg::div_cell_t chain [NC+1];

    vtp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_axis_tvalid),
        .pos_x    (s_axis_tdata[31:0]),
        .pos_y    (s_axis_tdata[63:32]),
        .pos_z    (s_axis_tdata[95:64]),
        .coef     (coef_reg),
        .cell_out (chain[0])
    );

    // row of divider cells, one quotient bit each
    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        vtp_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // sign, saturation and zero-divisor handling of the quotients
    vtp_pkg::div_cell_t last;
    logic [vtp_pkg::W-1:0] px;
    logic [vtp_pkg::W-1:0] py;
    logic sx;
    logic sy;
    logic signed [vtp_pkg::W+24:0] qxs;
    logic signed [vtp_pkg::W+24:0] qys;

    always_comb
    begin
        last = chain[NC];
        qxs = (vtp_pkg::W+25)'({1'b0, last.qx});
        qys = (vtp_pkg::W+25)'({1'b0, last.qy});
        if (last.negx) qxs = -qxs;
        if (last.negy) qys = -qys;
        px = vtp_pkg::sat32(qxs, sx);
        py = vtp_pkg::sat32(qys, sy);
        if (last.zero)
        begin
            px = '0;
            py = '0;
            sx = 1'b0;
            sy = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= last.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {last.depth, py, px};
            out_user_reg <= {last.sat | sx | sy, last.zero};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef SYNTHESIS
    // zero divisor forces both projections to zero
    a_zero_proj: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("projection not zero on zero divisor");
    // zero divisor flag agrees with depth
    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[95:64] == 32'd0)))
        else $error("zero flag and depth disagree");
    // a stalled output item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output item changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: tb/vtp_checker.sv
// ----------------------------------------------------------------------------
// vtp_checker
// Scoreboard for the vertex transform and perspective divide block. It
// mirrors the coefficient registers from the write port and predicts one
// projected vertex for each item taken on the input stream. Each item seen on
// the output stream is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vtp_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [63:0] cfg_data,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [95:0] s_axis_tdata,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [95:0] m_axis_tdata,
    input  wire  [1:0]  m_axis_tuser,
    output int          fail_count,
    output int          pending,
    output int          vertex_count,
    output int          zero_div_count,
    output int          sat_count
);

    typedef struct packed {
        logic [31:0] proj_x;
        logic [31:0] proj_y;
        logic [31:0] depth;
        logic        zero_divisor;
        logic        saturated;
    } vertex_out_t;

    logic [63:0]  coef [0:5];
    vertex_out_t  projected_q [$];

    // one matrix row: exact sum, then round half up to the fixed-point grid
    function automatic logic signed [79:0] row_sum(input logic [63:0] ra,
                                                   input logic [63:0] rb,
                                                   input logic signed [79:0] x,
                                                   input logic signed [79:0] y,
                                                   input logic signed [79:0] z);
        logic signed [79:0] wx;
        logic signed [79:0] wy;
        logic signed [79:0] wz;
        logic signed [79:0] off;
        logic signed [79:0] acc;
        begin
            wx  = $signed(ra[31:0]);
            wy  = $signed(ra[63:32]);
            wz  = $signed(rb[31:0]);
            off = $signed(rb[63:32]);
            acc = (off <<< vtp_pkg::FRAC_BITS) + wx * x + wy * y + wz * z
                + (80'sd1 <<< (vtp_pkg::FRAC_BITS - 1));
            row_sum = acc >>> vtp_pkg::FRAC_BITS;
        end
    endfunction

    function automatic logic signed [79:0] clamp32(input logic signed [79:0] v,
                                                   output logic clipped);
        begin
            clipped = 1'b0;
            clamp32 = v;
            if (v > 80'sd2147483647) begin
                clipped = 1'b1;
                clamp32 = 80'sd2147483647;
            end
            else if (v < -80'sd2147483648) begin
                clipped = 1'b1;
                clamp32 = -80'sd2147483648;
            end
        end
    endfunction

    function automatic vertex_out_t project_vertex(input logic [95:0] pos);
        logic signed [79:0] x;
        logic signed [79:0] y;
        logic signed [79:0] z;
        logic signed [79:0] tx;
        logic signed [79:0] ty;
        logic signed [79:0] tz;
        logic signed [79:0] dep;
        logic signed [79:0] px;
        logic signed [79:0] py;
        logic               fx;
        logic               fy;
        logic               fd;
        logic               fqx;
        logic               fqy;
        vertex_out_t        r;
        begin
            x   = $signed(pos[31:0]);
            y   = $signed(pos[63:32]);
            z   = $signed(pos[95:64]);
            tx  = clamp32(row_sum(coef[vtp_pkg::REG_X_A], coef[vtp_pkg::REG_X_B],
                                  x, y, z), fx);
            ty  = clamp32(row_sum(coef[vtp_pkg::REG_Y_A], coef[vtp_pkg::REG_Y_B],
                                  x, y, z), fy);
            tz  = row_sum(coef[vtp_pkg::REG_Z_A], coef[vtp_pkg::REG_Z_B], x, y, z);
            dep = clamp32(tz - (80'sd1 <<< vtp_pkg::FRAC_BITS), fd);
            px  = 0;
            py  = 0;
            fqx = 1'b0;
            fqy = 1'b0;
            r.zero_divisor = (dep == 0);
            // divide only when the divisor is nonzero; quotient truncates to zero
            if (!r.zero_divisor) begin
                px = clamp32((tx <<< vtp_pkg::FRAC_BITS) / dep, fqx);
                py = clamp32((ty <<< vtp_pkg::FRAC_BITS) / dep, fqy);
            end
            r.proj_x    = px[31:0];
            r.proj_y    = py[31:0];
            r.depth     = dep[31:0];
            r.saturated = fd | (!r.zero_divisor & (fx | fy | fqx | fqy));
            project_vertex = r;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("mismatch at vertex %0d: %s got %h expected %h",
                     vertex_count, what, got, want);
            fail_count++;
        end
    endtask

    // register mirror, input predictions and output comparison
    always @(posedge clk or negedge rst_n)
    begin
        vertex_out_t want;
        vertex_out_t got;
        if (!rst_n)
        begin
            coef[vtp_pkg::REG_X_A] = 64'd65536;
            coef[vtp_pkg::REG_X_B] = 64'd0;
            coef[vtp_pkg::REG_Y_A] = 64'd281474976710656;
            coef[vtp_pkg::REG_Y_B] = 64'd0;
            coef[vtp_pkg::REG_Z_A] = 64'd0;
            coef[vtp_pkg::REG_Z_B] = 64'd65536;
            projected_q.delete();
        end
        else
        begin
            if (cfg_we && cfg_index <= vtp_pkg::REG_Z_B)
                coef[cfg_index] = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                projected_q.insert(projected_q.size(), project_vertex(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.proj_x       = m_axis_tdata[31:0];
                got.proj_y       = m_axis_tdata[63:32];
                got.depth        = m_axis_tdata[95:64];
                got.zero_divisor = m_axis_tuser[0];
                got.saturated    = m_axis_tuser[1];
                if (projected_q.size() == 0)
                begin
                    $display("output item with no vertex outstanding");
                    fail_count++;
                end
                else
                begin
                    want = projected_q.pop_front();
                    if (got.proj_x != want.proj_x)
                        report_mismatch("proj_x", got.proj_x, want.proj_x);
                    if (got.proj_y != want.proj_y)
                        report_mismatch("proj_y", got.proj_y, want.proj_y);
                    if (got.depth != want.depth)
                        report_mismatch("depth", got.depth, want.depth);
                    if (got.zero_divisor != want.zero_divisor)
                        report_mismatch("zero_divisor", got.zero_divisor,
                                        want.zero_divisor);
                    if (got.saturated != want.saturated)
                        report_mismatch("saturated", got.saturated,
                                        want.saturated);
                    zero_div_count += want.zero_divisor;
                    sat_count      += want.saturated;
                end
                vertex_count++;
            end
        end
        pending = projected_q.size();
    end

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        vertex_count   = 0;
        zero_div_count = 0;
        sat_count      = 0;
    end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the vertex transform and perspective divide block.
// Loads several matrices, extremes among them, sends directed and random
// vertices in bursts while the output side stalls, and lets the checker
// compare every projected vertex.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         LIMIT      = 400000;
    localparam int         DRAIN      = 60;
    localparam int         HOLD_LEN   = 300;
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [31:0] ONE       = 32'h0001_0000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count;
    int pending;
    int vertex_count;
    int zero_div_count;
    int sat_count;
    int cycles;
    int burst_left;
    int matrices;
    bit hold_req;

    vertex_transform_project DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    vtp_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .fail_count     (fail_count),
        .pending        (pending),
        .vertex_count   (vertex_count),
        .zero_div_count (zero_div_count),
        .sat_count      (sat_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // output side: changing stall pattern, plus one long hold-off on request
    initial
    begin
        int mode;
        int left;
        bit held;
        mode = 0;
        left = 0;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_coef();
        begin
            case ($urandom_range(0, 4))
                0: rand_coef = $urandom;
                1: rand_coef = 32'($urandom_range(0, 524288)) - 32'd262144;
                2: rand_coef = 32'd0;
                3: rand_coef = $urandom_range(0, 1) ? ONE : -ONE;
                default: rand_coef = 32'($urandom_range(0, 65536)) - 32'd32768;
            endcase
        end
    endfunction

    function automatic logic [31:0] rand_pos();
        begin
            case ($urandom_range(0, 3))
                0: rand_pos = $urandom;
                1: rand_pos = 32'($urandom_range(0, 4194304)) - 32'd2097152;
                default: rand_pos = 32'($urandom_range(0, 16777216)) - 32'd8388608;
            endcase
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
    endtask

    // load a whole matrix; the enable drops once after the last write
    task automatic load_matrix(input logic [63:0] xa, input logic [63:0] xb,
                               input logic [63:0] ya, input logic [63:0] yb,
                               input logic [63:0] za, input logic [63:0] zb);
        begin
            write_reg(vtp_pkg::REG_X_A, xa);
            write_reg(vtp_pkg::REG_X_B, xb);
            write_reg(vtp_pkg::REG_Y_A, ya);
            write_reg(vtp_pkg::REG_Y_B, yb);
            write_reg(vtp_pkg::REG_Z_A, za);
            write_reg(vtp_pkg::REG_Z_B, zb);
            write_reg(REG_UNUSED, {$urandom, $urandom});
            cfg_we <= 1'b0;
            @(posedge clk);
            matrices++;
        end
    endtask

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
        int gap;
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 3) == 1 ? 60 : $urandom_range(1, 16);
                if (gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {z, y, x};
            do @(posedge clk); while (!s_axis_tready);
        end
    endtask

    // wait for every outstanding vertex, then let the pipeline settle
    task automatic drain();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (pending != 0) @(posedge clk);
            repeat (DRAIN) @(posedge clk);
        end
    endtask

    task automatic random_vertices(input int n);
        begin
            repeat (n) send_vertex(rand_pos(), rand_pos(), rand_pos());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = vtp_pkg::REG_X_A;
        cfg_data      = 64'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 96'd0;
        hold_req      = 1'b0;
        burst_left    = 0;
        matrices      = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed vertices on the identity matrix after reset
        send_vertex(32'd0, 32'd0, 32'd0);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, ONE);
        send_vertex(32'h0003_0000, 32'hfffd_0000, ONE);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, ONE + 32'd1);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, ONE - 32'd1);
        send_vertex(32'h0002_0000, 32'h0004_0000, 32'h0003_0000);
        send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        send_vertex(32'h1234_5678, 32'hedcb_a987, 32'h0000_8000);
        drain();

        // extreme matrices: all maximum, all minimum, all zero but a z offset of one
        load_matrix({2{32'h7fff_ffff}}, {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}},
                    {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}});
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'd0, 32'd0, 32'd0);
        send_vertex(32'd1, 32'hffff_ffff, 32'd0);
        drain();
        load_matrix({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                    {2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}});
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'd0, 32'd0, 32'd0);
        drain();
        load_matrix(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, {ONE, 32'd0});
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
        send_vertex(32'd0, 32'd0, 32'd0);
        drain();

        // random matrices; one phase with a long output hold-off, one with
        // a mid-phase pause until all results are back
        for (int ph = 0; ph < 6; ph++)
        begin
            load_matrix({rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                        {rand_coef(), rand_coef()}, {rand_coef(), rand_coef()},
                        {rand_coef(), rand_coef()}, {rand_coef(), rand_coef()});
            if (ph == 1)
                hold_req = 1'b1;
            random_vertices(60);
            if (ph == 3)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
                burst_left = 0;
            end
            random_vertices(60);
            drain();
        end

        // perspective-like matrix with z offset so depths cross zero often
        load_matrix({32'd0, ONE}, 64'd0, {ONE, 32'd0}, 64'd0, 64'd0, {ONE, ONE});
        for (int i = 0; i < 40; i++)
            send_vertex(rand_pos(), rand_pos(),
                        $urandom_range(0, 3) == 0 ? 32'd0 : rand_pos());
        drain();

        // back to the reset identity
        load_matrix(64'd65536, 64'd0, 64'd281474976710656, 64'd0, 64'd0, 64'd65536);
        random_vertices(40);
        drain();

        $display("covered %0d vertices over %0d loaded matrices plus reset values",
                 vertex_count, matrices);
        $display("zero-divisor results %0d, saturated results %0d",
                 zero_div_count, sat_count);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/vtp_pkg.sv
rtl/vtp_div_cell.sv
rtl/vtp_front.sv
rtl/vertex_transform_project.sv
tb/vtp_checker.sv
tb/testbench.sv
